// ===== design/hkie_pkg.sv =====
// Package for the hashed key index engine: sizes, codes, FNV-1a constants.
// No dependencies.
package hkie_pkg;

  localparam int unsigned SlotW    = 10;
  localparam int unsigned Slots    = 1 << SlotW;
  localparam int unsigned KeyBytes = 11;
  localparam int unsigned RecW     = 10;
  localparam int unsigned CntW     = 11;
  localparam int unsigned MetaW    = 44;
  localparam int unsigned KhlW     = 28;
  localparam int unsigned SlotDW   = MetaW + 64 + KhlW;

  localparam logic [31:0] FnvOffset = 32'd2166136261;
  localparam logic [31:0] FnvPrime  = 32'd16777619;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_UPSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTYKEY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_FRD, S_FCHK, S_IRD, S_ICHK,
    S_POP, S_POPW, S_WRITE, S_DONE
  } state_e;

endpackage

// ===== design/hkie_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module hkie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== design/hkie_hash.sv =====
// FNV-1a hash of the key, one byte per cycle; zero hash maps to 1.
// Depends on hkie_pkg.
module hkie_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] klo_i,
  input  logic [23:0] khi_i,
  input  logic [3:0]  len_i,
  output logic        done_o,
  output logic [31:0] hash_o
);
  import hkie_pkg::*;

  logic [31:0] h_q, h_d;
  logic [3:0]  idx_q, idx_d;
  logic        run_q, run_d;
  logic [7:0]  byte_w;
  logic [31:0] prod;
  logic [87:0] kall;

  assign kall   = {khi_i, klo_i};
  assign byte_w = kall[{idx_q, 3'b000} +: 8];
  assign prod   = (h_q ^ {24'd0, byte_w}) * FnvPrime;

  // byte loop
  always_comb begin
    h_d   = h_q;
    idx_d = idx_q;
    run_d = run_q;
    if (start_i) begin
      h_d   = FnvOffset;
      idx_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      h_d   = prod;
      idx_d = idx_q + 4'd1;
      if (idx_q + 4'd1 == len_i) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      idx_q <= '0;
      h_q   <= '0;
    end else begin
      run_q <= run_d;
      idx_q <= idx_d;
      h_q   <= h_d;
    end
  end

  assign done_o = !run_q && !start_i;
  assign hash_o = (h_q == 32'd0) ? 32'd1 : h_q;
endmodule

// ===== design/hashed_key_index_engine.sv =====
// Top level of the hashed key index engine: FSM, slot memory and free stack.
// Depends on hkie_pkg, hkie_ram, hkie_hash.
//
//  channel  | ports                                         | handshake
//  request  | req_type_i key_low_bytes_i key_high_bytes_i   | start_i & !busy_o
//           | key_length_i                                  |
//  result   | status_o was_present_o record_number_o        | done_o, one cycle
//           | entry_count_o                                 |
//
// An item passes idle, the hash and a lookup scan that reads and checks each
// probed slot (FRD, FCHK); an unmatched insert scans again (IRD, ICHK) over the
// one-port slot memory and picks a record (POP, then POPW when it comes off the
// free stack); inserts and removes write the slot; every item ends in the answer,
// empty keys at once. After reset a clearing pass zeroes all 1024 slots; busy_o
// stays high meanwhile. The receiver cannot stall: done_o is a single pulse.
module hashed_key_index_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] key_low_bytes_i,
  input  logic [23:0] key_high_bytes_i,
  input  logic [3:0]  key_length_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        was_present_o,
  output logic [9:0]  record_number_o,
  output logic [10:0] entry_count_o
);
  import hkie_pkg::*;

  state_e state_q, state_d;
  logic [1:0]  op_q;
  logic [63:0] klo_q;
  logic [23:0] khi_q;
  logic [3:0]  len_q;
  logic [SlotW:0]   cnt_q, cnt_d;
  logic [SlotW-1:0] s_q, s_d;
  logic [SlotW-1:0] ws_q, ws_d;
  logic [RecW-1:0]  rec_q, rec_d;
  logic [1:0]  st_q, st_d;
  logic        pres_q, pres_d;
  logic        tomb_ok_q, tomb_ok_d;
  logic [CntW-1:0] free_top_q, free_top_d, next_q, next_d, live_q, live_d;
  logic [31:0] hash;
  logic        hash_done, hash_go;
  // remove pushes only if there was room: tracked in FCHK
  logic        push_ok_q;

  // capture and trim key
  logic [3:0]  len_c;
  logic [63:0] klo_c;
  logic [23:0] khi_c;
  always_comb begin
    len_c = (key_length_i > 4'(KeyBytes)) ? 4'(KeyBytes) : key_length_i;
    klo_c = key_low_bytes_i;
    khi_c = key_high_bytes_i;
    for (int b = 0; b < 8; b++) if (b >= len_c) klo_c[b*8 +: 8] = 8'd0;
    for (int b = 0; b < 3; b++) if (b + 8 >= len_c) khi_c[b*8 +: 8] = 8'd0;
  end

  logic accept;
  assign accept  = start_i && !busy_o;
  assign hash_go = accept && (len_c != 4'd0);

  hkie_hash u_hash (
    .clk_i, .rst_ni, .start_i(hash_go),
    .klo_i(klo_q), .khi_i(khi_q), .len_i(len_q),
    .done_o(hash_done), .hash_o(hash)
  );

  // slot memory: meta, key low, key high+len
  logic              slot_we;
  logic [SlotW-1:0]  slot_addr;
  logic [SlotDW-1:0] slot_wd, slot_rd;
  hkie_ram #(.Width(SlotDW), .Depth(Slots)) u_slot (
    .clk_i, .we_i(slot_we), .addr_i(slot_addr), .wdata_i(slot_wd), .rdata_o(slot_rd)
  );

  // free stack
  logic             fs_we;
  logic [SlotW-1:0] fs_addr;
  logic [RecW-1:0]  fs_rd;
  hkie_ram #(.Width(RecW), .Depth(Slots)) u_free (
    .clk_i, .we_i(fs_we), .addr_i(fs_addr), .wdata_i(rec_q), .rdata_o(fs_rd)
  );

  logic [43:0] m_rd;
  logic [31:0] m_hash;
  logic        m_occ, m_tomb, m_never, m_match;
  assign m_rd    = slot_rd[SlotDW-1 -: MetaW];
  assign m_hash  = m_rd[31:0];
  assign m_occ   = m_rd[42];
  assign m_tomb  = m_rd[43];
  assign m_never = (m_hash == 32'd0) && !m_occ && !m_tomb;
  assign m_match = m_occ && (m_hash == hash) && (slot_rd[KhlW +: 64] == klo_q)
                   && (slot_rd[KhlW-1:0] == {len_q, khi_q});

  logic last_probe;
  assign last_probe = (cnt_q == (SlotW+1)'(Slots - 1));

  // next state and datapath
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; s_d = s_q; ws_d = ws_q; rec_d = rec_q;
    st_d = st_q; pres_d = pres_q; tomb_ok_d = tomb_ok_q;
    free_top_d = free_top_q; next_d = next_q; live_d = live_q;
    unique case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (SlotW+1)'(Slots - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (accept) begin
        rec_d = '0; pres_d = 1'b0; cnt_d = '0; tomb_ok_d = 1'b0;
        if (len_c == 4'd0) begin
          st_d = ST_EMPTYKEY; state_d = S_DONE;
        end else begin
          st_d = ST_NOTFOUND; state_d = S_HASH;
        end
      end
      S_HASH: if (hash_done) begin
        s_d = hash[SlotW-1:0]; state_d = S_FRD;
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        if (m_never) begin
          if (op_q == REQ_UPSERT) begin
            s_d = hash[SlotW-1:0]; cnt_d = '0; state_d = S_IRD;
          end else state_d = S_DONE;
        end else if (m_match) begin
          rec_d = m_rd[41:32]; pres_d = 1'b1; st_d = ST_OK; ws_d = s_q;
          if (op_q == REQ_REMOVE) begin
            state_d = S_WRITE;
            if (free_top_q < CntW'(Slots)) free_top_d = free_top_q + 1'b1;
            if (live_q != '0) live_d = live_q - 1'b1;
          end else state_d = S_DONE;
          if (op_q == REQ_NONE) begin
            st_d = ST_NOTFOUND; pres_d = 1'b0; rec_d = '0;
          end
        end else if (last_probe) begin
          if (op_q == REQ_UPSERT) begin
            s_d = hash[SlotW-1:0]; cnt_d = '0; state_d = S_IRD;
          end else state_d = S_DONE;
        end else begin
          s_d = s_q + 1'b1; cnt_d = cnt_q + 1'b1; state_d = S_FRD;
        end
      end
      S_IRD: state_d = S_ICHK;
      S_ICHK: begin
        if (m_tomb && !tomb_ok_q) begin
          tomb_ok_d = 1'b1; ws_d = s_q;
        end
        if (m_never) begin
          if (!(m_tomb && !tomb_ok_q) && !tomb_ok_q) ws_d = s_q;
          tomb_ok_d = 1'b1; state_d = S_POP;
        end else if (last_probe) begin
          if (tomb_ok_q || m_tomb) state_d = S_POP;
          else begin
            st_d = ST_FULL; state_d = S_DONE;
          end
        end else begin
          s_d = s_q + 1'b1; cnt_d = cnt_q + 1'b1; state_d = S_IRD;
        end
      end
      S_POP: begin
        st_d = ST_OK; live_d = live_q + 1'b1;
        if (free_top_q != '0 && free_top_q <= CntW'(Slots)) begin
          free_top_d = free_top_q - 1'b1; state_d = S_POPW;
        end else begin
          rec_d = next_q[RecW-1:0]; next_d = next_q + 1'b1; state_d = S_WRITE;
        end
      end
      S_POPW: begin
        rec_d = fs_rd; state_d = S_WRITE;
      end
      S_WRITE: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    slot_we = 1'b0; slot_addr = s_q; slot_wd = '0;
    fs_we = 1'b0; fs_addr = free_top_q[SlotW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        slot_we = 1'b1; slot_addr = cnt_q[SlotW-1:0];
      end
      // read the top entry so it is on fs_rd in POPW
      S_POP: begin
        fs_addr = SlotW'(free_top_q - 1'b1);
      end
      S_WRITE: begin
        slot_we = 1'b1; slot_addr = ws_q;
        if (op_q == REQ_REMOVE) begin
          slot_wd = {2'b10, rec_q, 32'd0, 64'd0, 28'd0};
          fs_we   = push_ok_q;
          fs_addr = SlotW'(free_top_q - 1'b1);
        end else begin
          slot_wd = {2'b01, rec_q, hash, klo_q, len_q, khi_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; free_top_q <= '0; next_q <= '0;
      live_q <= '0; push_ok_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; free_top_q <= free_top_d;
      next_q <= next_d; live_q <= live_d;
      if (state_q == S_FCHK) push_ok_q <= free_top_q < CntW'(Slots);
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; ws_q <= ws_d; rec_q <= rec_d; st_q <= st_d; pres_q <= pres_d;
    tomb_ok_q <= tomb_ok_d;
    if (accept) begin
      op_q <= req_type_i; klo_q <= klo_c; khi_q <= khi_c; len_q <= len_c;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign status_o        = st_q;
  assign was_present_o   = pres_q;
  assign record_number_o = rec_q;
  assign entry_count_o   = live_q;

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done repeated");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CntW'(Slots)) else $error("live count overflow");
  a_ok_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && st_q != ST_OK |-> rec_q == '0 && !pres_q) else $error("stray record");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= CntW'(Slots)) else $error("free stack overflow");
`endif
endmodule
